[rtl/aabb_obb_overlap_test_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the box overlap test block
// ---------------------------------------------------------------------------
`ifndef AABB_OBB_OVERLAP_TEST_MACROS_SVH
`define AABB_OBB_OVERLAP_TEST_MACROS_SVH

// same-cycle implication
`define AABBOBB_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define AABBOBB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/aabbobb_pkg.sv]
// ---------------------------------------------------------------------------
// aabbobb_pkg
// Shared constants for the box overlap test: widths, scaling, CSR indexes.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package aabbobb_pkg;

   localparam int unsigned COORD_WIDTH_DEFAULT = 20;
   localparam int unsigned TRIG_WIDTH          = 16;

   // Q1.14 trig: 2^15 on the distance side, 2^14 on the box-size side
   localparam int unsigned LHS_SHIFT = TRIG_WIDTH - 1;
   localparam int unsigned RHS_SHIFT = TRIG_WIDTH - 2;

   // register stages, output register included
   localparam int unsigned NUM_STAGES = 5;

   localparam int unsigned CSR_INDEX_WIDTH = 3;

   typedef logic [CSR_INDEX_WIDTH-1:0] csr_index_type;
   typedef logic [TRIG_WIDTH-1:0]      trig_mag_type;

   localparam csr_index_type CSR_FIXED_CENTER_X = 3'd0;
   localparam csr_index_type CSR_FIXED_CENTER_Y = 3'd1;
   localparam csr_index_type CSR_FIXED_CENTER_Z = 3'd2;
   localparam csr_index_type CSR_FIXED_SIZE_X   = 3'd3;
   localparam csr_index_type CSR_FIXED_SIZE_Y   = 3'd4;
   localparam csr_index_type CSR_FIXED_SIZE_Z   = 3'd5;

endpackage

[rtl/aabb_obb_overlap_test.sv]
// Five register stages, each with its own valid bit; an accepted item passes all five
// on its way to rsp_valid. Throughput: one item per cycle while req_stall is low.
// Empty stages close up under rsp_stall, so req_stall rises only when all five are full.
// Reset (synchronous, active high) clears every valid bit and all six box registers.
// ---------------------------------------------------------------------------
// aabb_obb_overlap_test
// Separating axis test between a configured axis-aligned box and a stream
// of boxes turned about the vertical axis. One overlap flag per item.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "aabb_obb_overlap_test_macros.svh"

module aabb_obb_overlap_test #(
   parameter int unsigned COORD_WIDTH = aabbobb_pkg::COORD_WIDTH_DEFAULT
) (
   input  logic                                    clock,
   input  logic                                    reset,
   // configuration
   input  logic                                    csr_write_en,
   input  logic [aabbobb_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [COORD_WIDTH-1:0]                  csr_wdata,
   // turned box items
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic signed [COORD_WIDTH-1:0]           req_turned_center_x,
   input  logic signed [COORD_WIDTH-1:0]           req_turned_center_y,
   input  logic signed [COORD_WIDTH-1:0]           req_turned_center_z,
   input  logic [COORD_WIDTH-2:0]                  req_turned_size_x,
   input  logic [COORD_WIDTH-2:0]                  req_turned_size_y,
   input  logic [COORD_WIDTH-2:0]                  req_turned_size_z,
   input  logic signed [aabbobb_pkg::TRIG_WIDTH-1:0] req_cos_yaw,
   input  logic signed [aabbobb_pkg::TRIG_WIDTH-1:0] req_sin_yaw,
   // results
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic                                    rsp_overlap
);

   import aabbobb_pkg::*;

   // Widths. CW: center, SW: size, DW: center difference,
   // VW: doubled vertical bounds, PW: difference times trig,
   // MW: size times trig magnitude, NW: c*c+s*s,
   // RW: world-axis compare, BW: projected difference, TXW: turned-axis compare.
   localparam int unsigned CW  = COORD_WIDTH;
   localparam int unsigned SW  = CW - 1;
   localparam int unsigned DW  = CW + 1;
   localparam int unsigned VW  = CW + 2;
   localparam int unsigned PW  = DW + TRIG_WIDTH;
   localparam int unsigned MW  = SW + TRIG_WIDTH;
   localparam int unsigned NW  = 2 * TRIG_WIDTH;
   localparam int unsigned RW  = MW + 2;
   localparam int unsigned BW  = PW + 1;
   localparam int unsigned AW  = BW - 1;
   localparam int unsigned ONW = SW + NW;
   localparam int unsigned TXW = AW + LHS_SHIFT;

   // -----------------------------------------------------------------------
   // Configuration registers: the axis-aligned box
   // -----------------------------------------------------------------------
   logic signed [CW-1:0] cfg_center_x_ff, cfg_center_y_ff, cfg_center_z_ff;
   logic [SW-1:0]        cfg_size_x_ff, cfg_size_y_ff, cfg_size_z_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_center_x_ff <= '0;
         cfg_center_y_ff <= '0;
         cfg_center_z_ff <= '0;
         cfg_size_x_ff   <= '0;
         cfg_size_y_ff   <= '0;
         cfg_size_z_ff   <= '0;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_FIXED_CENTER_X: cfg_center_x_ff <= csr_wdata;
            CSR_FIXED_CENTER_Y: cfg_center_y_ff <= csr_wdata;
            CSR_FIXED_CENTER_Z: cfg_center_z_ff <= csr_wdata;
            CSR_FIXED_SIZE_X:   cfg_size_x_ff   <= csr_wdata[SW-1:0];
            CSR_FIXED_SIZE_Y:   cfg_size_y_ff   <= csr_wdata[SW-1:0];
            CSR_FIXED_SIZE_Z:   cfg_size_z_ff   <= csr_wdata[SW-1:0];
            default: ;  // indexes past the list are dropped
         endcase
      end
   end

   // -----------------------------------------------------------------------
   // Pipeline flow control. A stage loads when it is empty or when the
   // stage after it loads; the output register loads when rsp is not stalled.
   // -----------------------------------------------------------------------
   logic [NUM_STAGES-1:0] valid_ff, valid_in;
   logic [NUM_STAGES:0]   en;

   always_comb begin
      en[NUM_STAGES] = !rsp_stall;
      for (int k = NUM_STAGES - 1; k >= 0; k--) begin
         en[k] = !valid_ff[k] || en[k+1];
      end
      valid_in[0] = en[0] ? req_valid : valid_ff[0];
      for (int k = 1; k < NUM_STAGES; k++) begin
         valid_in[k] = en[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_stall = !en[0];
   assign rsp_valid = valid_ff[NUM_STAGES-1];

   // -----------------------------------------------------------------------
   // Stage 1: center differences, trig magnitudes, vertical interval test.
   // The vertical test runs on doubled values so the half sizes stay exact.
   // -----------------------------------------------------------------------
   logic signed [DW-1:0]          s1_dx_in, s1_dy_in, s1_dx_ff, s1_dy_ff;
   logic signed [TRIG_WIDTH-1:0]  s1_cos_ff, s1_sin_ff;
   trig_mag_type                  s1_acos_in, s1_asin_in, s1_acos_ff, s1_asin_ff;
   logic [SW-1:0]                 s1_osx_ff, s1_osy_ff;
   logic                          s1_vert_in, s1_vert_ff;
   logic signed [VW-1:0]          fix_top, fix_bot, trn_top, trn_bot;

   always_comb begin
      s1_dx_in = DW'(req_turned_center_x) - DW'(cfg_center_x_ff);
      s1_dy_in = DW'(req_turned_center_y) - DW'(cfg_center_y_ff);
      // -(-32768) wraps to 16'h8000, which is the right unsigned magnitude
      s1_acos_in = req_cos_yaw[TRIG_WIDTH-1] ? trig_mag_type'(-req_cos_yaw)
                                             : trig_mag_type'(req_cos_yaw);
      s1_asin_in = req_sin_yaw[TRIG_WIDTH-1] ? trig_mag_type'(-req_sin_yaw)
                                             : trig_mag_type'(req_sin_yaw);
      fix_top = $signed({cfg_center_z_ff[CW-1], cfg_center_z_ff, 1'b0})
              + $signed({3'b000, cfg_size_z_ff});
      fix_bot = $signed({cfg_center_z_ff[CW-1], cfg_center_z_ff, 1'b0})
              - $signed({3'b000, cfg_size_z_ff});
      trn_top = $signed({req_turned_center_z[CW-1], req_turned_center_z, 1'b0})
              + $signed({3'b000, req_turned_size_z});
      trn_bot = $signed({req_turned_center_z[CW-1], req_turned_center_z, 1'b0})
              - $signed({3'b000, req_turned_size_z});
      // touching counts as overlap
      s1_vert_in = !((fix_top < trn_bot) || (trn_top < fix_bot));
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         s1_dx_ff   <= s1_dx_in;
         s1_dy_ff   <= s1_dy_in;
         s1_cos_ff  <= req_cos_yaw;
         s1_sin_ff  <= req_sin_yaw;
         s1_acos_ff <= s1_acos_in;
         s1_asin_ff <= s1_asin_in;
         s1_osx_ff  <= req_turned_size_x;
         s1_osy_ff  <= req_turned_size_y;
         s1_vert_ff <= s1_vert_in;
      end
   end

   // -----------------------------------------------------------------------
   // Stage 2: difference magnitudes; difference, size and trig products, one multiplier per term
   // -----------------------------------------------------------------------
   logic signed [PW-1:0] s2_dxc_in, s2_dys_in, s2_dyc_in, s2_dxs_in;
   logic signed [PW-1:0] s2_dxc_ff, s2_dys_ff, s2_dyc_ff, s2_dxs_ff;
   logic [DW-1:0]        s2_adx_in, s2_ady_in, s2_adx_ff, s2_ady_ff;
   logic [MW-1:0]        s2_osx_ac_ff, s2_osy_as_ff, s2_osx_as_ff, s2_osy_ac_ff;
   logic [MW-1:0]        s2_rsx_ac_ff, s2_rsy_as_ff, s2_rsx_as_ff, s2_rsy_ac_ff;
   logic [NW-1:0]        s2_cc_ff, s2_ss_ff;
   logic [SW-1:0]        s2_osx_ff, s2_osy_ff;
   logic                 s2_vert_ff;

   always_comb begin
      s2_dxc_in = s1_dx_ff * s1_cos_ff;
      s2_dys_in = s1_dy_ff * s1_sin_ff;
      s2_dyc_in = s1_dy_ff * s1_cos_ff;
      s2_dxs_in = s1_dx_ff * s1_sin_ff;
      s2_adx_in = s1_dx_ff[DW-1] ? DW'(-s1_dx_ff) : DW'(s1_dx_ff);
      s2_ady_in = s1_dy_ff[DW-1] ? DW'(-s1_dy_ff) : DW'(s1_dy_ff);
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         s2_dxc_ff    <= s2_dxc_in;
         s2_dys_ff    <= s2_dys_in;
         s2_dyc_ff    <= s2_dyc_in;
         s2_dxs_ff    <= s2_dxs_in;
         s2_adx_ff    <= s2_adx_in;
         s2_ady_ff    <= s2_ady_in;
         s2_osx_ac_ff <= MW'(s1_osx_ff) * MW'(s1_acos_ff);
         s2_osy_as_ff <= MW'(s1_osy_ff) * MW'(s1_asin_ff);
         s2_osx_as_ff <= MW'(s1_osx_ff) * MW'(s1_asin_ff);
         s2_osy_ac_ff <= MW'(s1_osy_ff) * MW'(s1_acos_ff);
         s2_rsx_ac_ff <= MW'(cfg_size_x_ff) * MW'(s1_acos_ff);
         s2_rsy_as_ff <= MW'(cfg_size_y_ff) * MW'(s1_asin_ff);
         s2_rsx_as_ff <= MW'(cfg_size_x_ff) * MW'(s1_asin_ff);
         s2_rsy_ac_ff <= MW'(cfg_size_y_ff) * MW'(s1_acos_ff);
         s2_cc_ff     <= NW'(s1_acos_ff) * NW'(s1_acos_ff);
         s2_ss_ff     <= NW'(s1_asin_ff) * NW'(s1_asin_ff);
         s2_osx_ff    <= s1_osx_ff;
         s2_osy_ff    <= s1_osy_ff;
         s2_vert_ff   <= s1_vert_ff;
      end
   end

   // -----------------------------------------------------------------------
   // Stage 3: projections, trig norm, world-axis and turned-axis radii
   // -----------------------------------------------------------------------
   logic signed [BW-1:0] s3_bc_ff, s3_bs_ff;
   logic [NW-1:0]        s3_norm_ff;
   logic [RW-1:0]        s3_rwx_ff, s3_rwy_ff, s3_rtx_ff, s3_rty_ff;
   logic [DW-1:0]        s3_adx_ff, s3_ady_ff;
   logic [SW-1:0]        s3_osx_ff, s3_osy_ff;
   logic                 s3_vert_ff;

   always_ff @(posedge clock) begin
      if (en[2]) begin
         s3_bc_ff   <= BW'(s2_dxc_ff) + BW'(s2_dys_ff);
         s3_bs_ff   <= BW'(s2_dyc_ff) - BW'(s2_dxs_ff);
         s3_norm_ff <= s2_cc_ff + s2_ss_ff;  // at most 2^31
         s3_rwx_ff  <= RW'({cfg_size_x_ff, {RHS_SHIFT{1'b0}}})
                     + RW'(s2_osx_ac_ff) + RW'(s2_osy_as_ff);
         s3_rwy_ff  <= RW'({cfg_size_y_ff, {RHS_SHIFT{1'b0}}})
                     + RW'(s2_osx_as_ff) + RW'(s2_osy_ac_ff);
         s3_rtx_ff  <= RW'(s2_rsx_ac_ff) + RW'(s2_rsy_as_ff);
         s3_rty_ff  <= RW'(s2_rsx_as_ff) + RW'(s2_rsy_ac_ff);
         s3_adx_ff  <= s2_adx_ff;
         s3_ady_ff  <= s2_ady_ff;
         s3_osx_ff  <= s2_osx_ff;
         s3_osy_ff  <= s2_osy_ff;
         s3_vert_ff <= s2_vert_ff;
      end
   end

   // -----------------------------------------------------------------------
   // Stage 4: world-axis compares, projection magnitudes, size * norm
   // -----------------------------------------------------------------------
   logic          s4_world_in, s4_world_ff;
   logic [AW-1:0] s4_abc_ff, s4_abs_ff;
   logic [ONW-1:0] s4_osxn_ff, s4_osyn_ff;
   logic [RW-1:0] s4_rtx_ff, s4_rty_ff;

   always_comb begin
      s4_world_in = s3_vert_ff
                 && (RW'({s3_adx_ff, {LHS_SHIFT{1'b0}}}) <= s3_rwx_ff)
                 && (RW'({s3_ady_ff, {LHS_SHIFT{1'b0}}}) <= s3_rwy_ff);
   end

   always_ff @(posedge clock) begin
      if (en[3]) begin
         s4_world_ff <= s4_world_in;
         s4_abc_ff   <= s3_bc_ff[BW-1] ? AW'(-s3_bc_ff) : AW'(s3_bc_ff);
         s4_abs_ff   <= s3_bs_ff[BW-1] ? AW'(-s3_bs_ff) : AW'(s3_bs_ff);
         s4_osxn_ff  <= ONW'(s3_osx_ff) * ONW'(s3_norm_ff);
         s4_osyn_ff  <= ONW'(s3_osy_ff) * ONW'(s3_norm_ff);
         s4_rtx_ff   <= s3_rtx_ff;
         s4_rty_ff   <= s3_rty_ff;
      end
   end

   // -----------------------------------------------------------------------
   // Stage 5 (output register): turned-axis compares
   // -----------------------------------------------------------------------
   logic          turned_x_ok, turned_y_ok;
   logic          rsp_overlap_in, rsp_overlap_ff;

   always_comb begin
      turned_x_ok = TXW'({s4_abc_ff, {LHS_SHIFT{1'b0}}})
                 <= TXW'({s4_rtx_ff, {RHS_SHIFT{1'b0}}}) + TXW'(s4_osxn_ff);
      turned_y_ok = TXW'({s4_abs_ff, {LHS_SHIFT{1'b0}}})
                 <= TXW'({s4_rty_ff, {RHS_SHIFT{1'b0}}}) + TXW'(s4_osyn_ff);
      rsp_overlap_in = s4_world_ff && turned_x_ok && turned_y_ok;
   end

   always_ff @(posedge clock) begin
      if (en[4]) begin
         rsp_overlap_ff <= rsp_overlap_in;
      end
   end

   assign rsp_overlap = rsp_overlap_ff;

   // -----------------------------------------------------------------------
   // Assertions
   // -----------------------------------------------------------------------
   `AABBOBB_ASSERT_SAME(a_stall_only_when_full, clock, reset, req_stall, &valid_ff, "req_stall with an empty stage")
   `AABBOBB_ASSERT_NEXT(a_accept_fills_entry, clock, reset, req_valid && !req_stall, valid_ff[0], "accepted item lost at entry")
   `AABBOBB_ASSERT_NEXT(a_last_stage_feeds_output, clock, reset, valid_ff[NUM_STAGES-2] && en[NUM_STAGES-1], rsp_valid, "item lost before output")

endmodule
